// File: hdl/fibonacci_result_cache_unit_assert.svh
// ----------------------------------------------------------------------------
// fibonacci result cache assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef FIBONACCI_RESULT_CACHE_UNIT_ASSERT_SVH
`define FIBONACCI_RESULT_CACHE_UNIT_ASSERT_SVH

// same-cycle implication
`define FRC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frc: same-cycle check failed");

// next-cycle implication
`define FRC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frc: next-cycle check failed");

`endif

// File: hdl/frc_pkg.sv
// ----------------------------------------------------------------------------
// frc_pkg
// widths, defaults and shared types of the fibonacci result cache
// ----------------------------------------------------------------------------
package frc_pkg;

    localparam int ENTRIES_DEF    = 20;
    localparam int MAX_INDEX_DEF  = 63;
    localparam int COUNT_BITS_DEF = 16;

    localparam int INDEX_W    = 6;
    localparam int VALUE_W    = 64;
    localparam int SLOT_OUT_W = 5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_FIB
    } t_state;

    // table write control: fill writes a whole entry, otherwise only the count
    typedef struct packed {
        logic en;
        logic fill;
    } t_tbl_wr;

endpackage

// File: hdl/frc_if.sv
// ----------------------------------------------------------------------------
// frc channel interfaces
// request and result channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface frc_req_if;
    logic                        valid;
    logic                        ready;
    logic [frc_pkg::INDEX_W-1:0] request_index;

    modport source (output valid, output request_index, input ready);
    modport sink   (input valid, input request_index, output ready);
endinterface

interface frc_res_if;
    logic                           valid;
    logic                           ready;
    logic [frc_pkg::VALUE_W-1:0]    fib_result;
    logic                           was_hit;
    logic [frc_pkg::SLOT_OUT_W-1:0] slot_used;

    modport source (output valid, output fib_result, output was_hit, output slot_used,
                    input ready);
    modport sink   (input valid, input fib_result, input was_hit, input slot_used,
                    output ready);
endinterface

// File: hdl/frc_table.sv
// ----------------------------------------------------------------------------
// frc_table
// entry storage: key, value and use count memories plus valid flags
// ----------------------------------------------------------------------------
module frc_table #(
    parameter int ENTRIES    = frc_pkg::ENTRIES_DEF,
    parameter int COUNT_BITS = frc_pkg::COUNT_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [$clog2(ENTRIES)-1:0]       i_rd_addr,
    output logic                             o_rd_valid,
    output logic [frc_pkg::INDEX_W-1:0]      o_rd_key,
    output logic [frc_pkg::VALUE_W-1:0]      o_rd_value,
    output logic [COUNT_BITS-1:0]            o_rd_count,
    input  frc_pkg::t_tbl_wr                 i_wr,
    input  logic [$clog2(ENTRIES)-1:0]       i_wr_addr,
    input  logic [frc_pkg::INDEX_W-1:0]      i_wr_key,
    input  logic [frc_pkg::VALUE_W-1:0]      i_wr_value,
    input  logic [COUNT_BITS-1:0]            i_wr_count
);

    logic [frc_pkg::INDEX_W-1:0] r_key_mem   [ENTRIES];
    logic [frc_pkg::VALUE_W-1:0] r_value_mem [ENTRIES];
    logic [COUNT_BITS-1:0]       r_count_mem [ENTRIES];
    logic [ENTRIES-1:0]          r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.en && i_wr.fill) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_count_mem[i_wr_addr] <= i_wr_count;
            if (i_wr.fill) begin
                r_key_mem[i_wr_addr]   <= i_wr_key;
                r_value_mem[i_wr_addr] <= i_wr_value;
            end
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rd_valid <= r_valid[i_rd_addr];
        o_rd_key   <= r_key_mem[i_rd_addr];
        o_rd_value <= r_value_mem[i_rd_addr];
        o_rd_count <= r_count_mem[i_rd_addr];
    end

endmodule

// File: hdl/frc_fib.sv
// ----------------------------------------------------------------------------
// frc_fib
// iterative fibonacci unit: one 64-bit addition per cycle
// ----------------------------------------------------------------------------
module frc_fib (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [frc_pkg::INDEX_W-1:0] i_n,
    output logic                        o_done,
    output logic [frc_pkg::VALUE_W-1:0] o_value
);

    logic [frc_pkg::VALUE_W-1:0] r_a;
    logic [frc_pkg::VALUE_W-1:0] r_b;
    logic [frc_pkg::INDEX_W-1:0] r_k;
    logic                        r_busy;
    logic                        r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy && r_k == '0) begin
            r_busy <= 1'b0;
            r_done <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= '0;
            r_b <= frc_pkg::VALUE_W'(1);
            r_k <= i_n;
        end else if (r_busy && r_k != '0) begin
            // a and b stay exact for every 6-bit index
            r_a <= r_b;
            r_b <= r_a + r_b;
            r_k <= r_k - 1'b1;
        end
    end

    assign o_done  = r_done;
    assign o_value = r_a;

endmodule

// File: hdl/frc_ctrl.sv
// ----------------------------------------------------------------------------
// frc_ctrl
// sequencer: table scan with one key and count compare per cycle,
// replacement choice, count update and miss fill
// ----------------------------------------------------------------------------
module frc_ctrl #(
    parameter int ENTRIES    = frc_pkg::ENTRIES_DEF,
    parameter int MAX_INDEX  = frc_pkg::MAX_INDEX_DEF,
    parameter int COUNT_BITS = frc_pkg::COUNT_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_req_valid,
    output logic                             o_req_ready,
    input  logic [frc_pkg::INDEX_W-1:0]      i_req_index,
    input  logic                             i_out_free,
    output logic                             o_res_load,
    output logic [frc_pkg::VALUE_W-1:0]      o_res_value,
    output logic                             o_res_hit,
    output logic [$clog2(ENTRIES)-1:0]       o_res_slot,
    output logic [$clog2(ENTRIES)-1:0]       o_rd_addr,
    input  logic                             i_rd_valid,
    input  logic [frc_pkg::INDEX_W-1:0]      i_rd_key,
    input  logic [frc_pkg::VALUE_W-1:0]      i_rd_value,
    input  logic [COUNT_BITS-1:0]            i_rd_count,
    output frc_pkg::t_tbl_wr                 o_wr,
    output logic [$clog2(ENTRIES)-1:0]       o_wr_addr,
    output logic [frc_pkg::INDEX_W-1:0]      o_wr_key,
    output logic [frc_pkg::VALUE_W-1:0]      o_wr_value,
    output logic [COUNT_BITS-1:0]            o_wr_count,
    output logic                             o_fib_start,
    output logic [frc_pkg::INDEX_W-1:0]      o_fib_n,
    input  logic                             i_fib_done,
    input  logic [frc_pkg::VALUE_W-1:0]      i_fib_sum
);

    localparam int SLOT_W = $clog2(ENTRIES);
    localparam int PTR_W  = $clog2(ENTRIES + 1);
    localparam logic [PTR_W-1:0]  PTR_END   = PTR_W'(ENTRIES);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(ENTRIES - 1);

    frc_pkg::t_state r_state;
    frc_pkg::t_state n_state;

    logic [frc_pkg::INDEX_W-1:0] r_n;
    logic [PTR_W-1:0]            r_ptr;
    logic                        r_cmp_vld;
    logic [SLOT_W-1:0]           r_cmp_slot;
    logic                        r_hit;
    logic [SLOT_W-1:0]           r_hit_slot;
    logic [frc_pkg::VALUE_W-1:0] r_hit_value;
    logic [COUNT_BITS-1:0]       r_hit_count;
    logic                        r_empty;
    logic [SLOT_W-1:0]           r_empty_slot;
    logic                        r_best_set;
    logic [COUNT_BITS-1:0]       r_best_count;
    logic [SLOT_W-1:0]           r_best_slot;
    logic [SLOT_W-1:0]           r_pick;

    logic                        req_xfer;
    logic                        ptr_live;
    logic [frc_pkg::INDEX_W-1:0] req_n;
    logic [COUNT_BITS-1:0]       hit_count_inc;

    assign req_xfer = (r_state == frc_pkg::ST_IDLE) && i_req_valid;
    assign ptr_live = (r_ptr < PTR_END);
    assign req_n    = (int'(i_req_index) > MAX_INDEX) ? frc_pkg::INDEX_W'(MAX_INDEX)
                                                      : i_req_index;
    // saturating hit count
    assign hit_count_inc = (&r_hit_count) ? r_hit_count : r_hit_count + 1'b1;
    assign o_fib_n       = r_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= frc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_req_ready = 1'b0;
        o_rd_addr   = '0;
        o_wr        = '0;
        o_wr_addr   = r_pick;
        o_wr_key    = r_n;
        o_wr_value  = i_fib_sum;
        o_wr_count  = '0;
        o_fib_start = 1'b0;
        o_res_load  = 1'b0;
        o_res_value = i_fib_sum;
        o_res_hit   = 1'b0;
        o_res_slot  = r_pick;
        case (r_state)
            frc_pkg::ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    n_state = frc_pkg::ST_SCAN;
                end
            end
            frc_pkg::ST_SCAN: begin
                if (ptr_live) begin
                    o_rd_addr = r_ptr[SLOT_W-1:0];
                end
                if (r_cmp_vld && r_cmp_slot == SLOT_LAST) begin
                    n_state = frc_pkg::ST_DECIDE;
                end
            end
            frc_pkg::ST_DECIDE: begin
                if (r_hit) begin
                    o_wr_addr  = r_hit_slot;
                    o_wr_count = hit_count_inc;
                    o_res_value = r_hit_value;
                    o_res_hit   = 1'b1;
                    o_res_slot  = r_hit_slot;
                    if (i_out_free) begin
                        o_wr.en    = 1'b1;
                        o_res_load = 1'b1;
                        n_state    = frc_pkg::ST_IDLE;
                    end
                end else begin
                    o_fib_start = 1'b1;
                    n_state     = frc_pkg::ST_FIB;
                end
            end
            frc_pkg::ST_FIB: begin
                if (i_fib_done && i_out_free) begin
                    o_wr.en    = 1'b1;
                    o_wr.fill  = 1'b1;
                    o_res_load = 1'b1;
                    n_state    = frc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = frc_pkg::ST_IDLE;
            end
        endcase
    end

    // scan bookkeeping; read data of a slot arrives in the cycle after its address
    always_ff @(posedge i_clk) begin
        if (req_xfer) begin
            r_n        <= req_n;
            r_ptr      <= '0;
            r_cmp_vld  <= 1'b0;
            r_hit      <= 1'b0;
            r_empty    <= 1'b0;
            r_best_set <= 1'b0;
        end else if (r_state == frc_pkg::ST_SCAN) begin
            if (ptr_live) begin
                r_ptr <= r_ptr + 1'b1;
            end
            r_cmp_vld  <= ptr_live;
            r_cmp_slot <= r_ptr[SLOT_W-1:0];
            if (r_cmp_vld) begin
                if (i_rd_valid && i_rd_key == r_n && !r_hit) begin
                    r_hit       <= 1'b1;
                    r_hit_slot  <= r_cmp_slot;
                    r_hit_value <= i_rd_value;
                    r_hit_count <= i_rd_count;
                end
                if (!i_rd_valid && !r_empty) begin
                    r_empty      <= 1'b1;
                    r_empty_slot <= r_cmp_slot;
                end
                // strict less keeps the lowest slot among equal counts
                if (i_rd_valid && (!r_best_set || i_rd_count < r_best_count)) begin
                    r_best_set   <= 1'b1;
                    r_best_count <= i_rd_count;
                    r_best_slot  <= r_cmp_slot;
                end
            end
        end else if (r_state == frc_pkg::ST_DECIDE) begin
            r_pick <= r_empty ? r_empty_slot : r_best_slot;
        end
    end

endmodule

// File: hdl/fibonacci_result_cache_unit.sv
// ----------------------------------------------------------------------------
// fibonacci_result_cache_unit
// Returns Fibonacci(n) for a 6-bit request index, with a hit flag and the
// table slot used. A request is taken only while the unit is idle. Each
// request first scans the fully associative table one slot per cycle through
// its registered read port. A hit then updates the saturating use count and
// delivers the result into the output register. A miss runs the single
// 64-bit adder once per index step and fills the first empty slot, or else
// the lowest slot with the smallest count. The next request is taken in the
// cycle after a result is loaded, even while that result still waits on the
// output side. Requests above MAX_INDEX are served as MAX_INDEX.
// ----------------------------------------------------------------------------
module fibonacci_result_cache_unit #(
    parameter int ENTRIES    = frc_pkg::ENTRIES_DEF,
    parameter int MAX_INDEX  = frc_pkg::MAX_INDEX_DEF,
    parameter int COUNT_BITS = frc_pkg::COUNT_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    frc_req_if.sink    i_req,
    frc_res_if.source  o_res
);

    localparam int SLOT_W = $clog2(ENTRIES);

    logic                           r_res_valid;
    logic [frc_pkg::VALUE_W-1:0]    r_res_value;
    logic                           r_res_hit;
    logic [frc_pkg::SLOT_OUT_W-1:0] r_res_slot;

    logic                        out_free;
    logic                        res_load;
    logic [frc_pkg::VALUE_W-1:0] res_value;
    logic                        res_hit;
    logic [SLOT_W-1:0]           res_slot;

    logic [SLOT_W-1:0]           rd_addr;
    logic                        rd_valid;
    logic [frc_pkg::INDEX_W-1:0] rd_key;
    logic [frc_pkg::VALUE_W-1:0] rd_value;
    logic [COUNT_BITS-1:0]       rd_count;
    frc_pkg::t_tbl_wr            tbl_wr;
    logic [SLOT_W-1:0]           wr_addr;
    logic [frc_pkg::INDEX_W-1:0] wr_key;
    logic [frc_pkg::VALUE_W-1:0] wr_value;
    logic [COUNT_BITS-1:0]       wr_count;

    logic                        fib_start;
    logic [frc_pkg::INDEX_W-1:0] fib_n;
    logic                        fib_done;
    logic [frc_pkg::VALUE_W-1:0] fib_sum;

    assign out_free = !r_res_valid || o_res.ready;

    frc_ctrl #(
        .ENTRIES    (ENTRIES),
        .MAX_INDEX  (MAX_INDEX),
        .COUNT_BITS (COUNT_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_req_index (i_req.request_index),
        .i_out_free  (out_free),
        .o_res_load  (res_load),
        .o_res_value (res_value),
        .o_res_hit   (res_hit),
        .o_res_slot  (res_slot),
        .o_rd_addr   (rd_addr),
        .i_rd_valid  (rd_valid),
        .i_rd_key    (rd_key),
        .i_rd_value  (rd_value),
        .i_rd_count  (rd_count),
        .o_wr        (tbl_wr),
        .o_wr_addr   (wr_addr),
        .o_wr_key    (wr_key),
        .o_wr_value  (wr_value),
        .o_wr_count  (wr_count),
        .o_fib_start (fib_start),
        .o_fib_n     (fib_n),
        .i_fib_done  (fib_done),
        .i_fib_sum   (fib_sum)
    );

    frc_table #(
        .ENTRIES    (ENTRIES),
        .COUNT_BITS (COUNT_BITS)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_addr  (rd_addr),
        .o_rd_valid (rd_valid),
        .o_rd_key   (rd_key),
        .o_rd_value (rd_value),
        .o_rd_count (rd_count),
        .i_wr       (tbl_wr),
        .i_wr_addr  (wr_addr),
        .i_wr_key   (wr_key),
        .i_wr_value (wr_value),
        .i_wr_count (wr_count)
    );

    frc_fib u_fib (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (fib_start),
        .i_n     (fib_n),
        .o_done  (fib_done),
        .o_value (fib_sum)
    );

    // output register, holds a result until its transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (res_load) begin
            r_res_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_res_value <= res_value;
            r_res_hit   <= res_hit;
            r_res_slot  <= frc_pkg::SLOT_OUT_W'(res_slot);
        end
    end

    assign o_res.valid      = r_res_valid;
    assign o_res.fib_result = r_res_value;
    assign o_res.was_hit    = r_res_hit;
    assign o_res.slot_used  = r_res_slot;

endmodule

// File: hdl/frc_checker.sv
// ----------------------------------------------------------------------------
// frc_checker
// port-level checks of the fibonacci result cache, bound to the top level
// ----------------------------------------------------------------------------
`include "fibonacci_result_cache_unit_assert.svh"

module frc_checker #(
    parameter int ENTRIES = frc_pkg::ENTRIES_DEF
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_req_valid,
    input logic                           i_req_ready,
    input logic                           i_res_valid,
    input logic                           i_res_ready,
    input logic [frc_pkg::VALUE_W-1:0]    i_res_fib_result,
    input logic                           i_res_was_hit,
    input logic [frc_pkg::SLOT_OUT_W-1:0] i_res_slot_used
);

    // a request transfer starts a scan, so no second request right after
    `FRC_ASSERT_NXT(a_busy_after_req, i_clk, i_rst_n, i_req_valid && i_req_ready, !i_req_ready)

    // a reported slot lies inside the table
    `FRC_ASSERT_IMP(a_slot_range, i_clk, i_rst_n, i_res_valid, (ENTRIES > 32) || (i_res_slot_used < ENTRIES))

    // a stalled result keeps its valid
    `FRC_ASSERT_NXT(a_res_hold, i_clk, i_rst_n, i_res_valid && !i_res_ready, i_res_valid)

    // a stalled result keeps its payload
    `FRC_ASSERT_NXT(a_res_stable, i_clk, i_rst_n, i_res_valid && !i_res_ready, $stable(i_res_fib_result) && $stable(i_res_was_hit) && $stable(i_res_slot_used))

endmodule

bind fibonacci_result_cache_unit frc_checker #(
    .ENTRIES (ENTRIES)
) u_frc_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_req_valid      (i_req.valid),
    .i_req_ready      (i_req.ready),
    .i_res_valid      (o_res.valid),
    .i_res_ready      (o_res.ready),
    .i_res_fib_result (o_res.fib_result),
    .i_res_was_hit    (o_res.was_hit),
    .i_res_slot_used  (o_res.slot_used)
);
